// File: design/pngcp_pkg.sv
// Shared types, constants and signature table for the PNG chunk stream parser.
package pngcp_pkg;

   localparam int POSITION_WIDTH = 32;
   localparam int CMP_WIDTH      = 34;
   localparam int SIG_LENGTH     = 8;
   localparam int FIELD_BYTES    = 4;
   localparam int HEADER_BYTES   = 8;
   localparam int FRAMING_BYTES  = 12;

   localparam logic [POSITION_WIDTH-1:0] POS_MAX = '1;

   localparam logic [1:0] KIND_DATA       = 2'd0;
   localparam logic [1:0] KIND_DESCRIPTOR = 2'd1;
   localparam logic [1:0] KIND_ERROR      = 2'd2;

   localparam logic [1:0] ERR_BAD_SIGNATURE = 2'd0;
   localparam logic [1:0] ERR_OVERRUN       = 2'd1;
   localparam logic [1:0] ERR_SHORT_HEADER  = 2'd2;

   localparam logic [7:0] SIG_BYTES [SIG_LENGTH] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };

   typedef enum logic [2:0] {
      PH_SIG,
      PH_LEN,
      PH_TYPE,
      PH_DATA,
      PH_CRC,
      PH_HALT,
      PH_END
   } pngcp_phase_type;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       start_of_file;
   } pngcp_req_type;

   typedef struct packed {
      logic [1:0]  result_kind;
      logic [7:0]  data_byte;
      logic [31:0] chunk_type;
      logic [31:0] byte_index;
      logic [31:0] chunk_length;
      logic [31:0] stored_crc;
      logic [1:0]  error_code;
   } pngcp_rsp_type;

   typedef struct packed {
      pngcp_phase_type             phase;
      logic [31:0]                 field_count;
      logic [31:0]                 length_reg;
      logic [31:0]                 type_reg;
      logic [31:0]                 crc_reg;
      logic [POSITION_WIDTH-1:0]   chunk_start;
   } pngcp_state_type;

   localparam pngcp_state_type STATE_CLEAR = '{phase: PH_SIG, default: '0};

endpackage

// File: design/pngcp_step.sv
// Per-byte parse step: next parser state and the result for one input byte.
module pngcp_step
   import pngcp_pkg::*;
(
   input  pngcp_state_type cur_state,
   input  pngcp_req_type   req_item,
   input  logic [31:0]     file_length,
   output pngcp_state_type next_state,
   output logic            result_valid,
   output pngcp_rsp_type   result
);

   pngcp_state_type       cur;
   logic [7:0]            b;
   logic [31:0]           count_inc;
   logic                  last_field;
   logic [31:0]           len_shift;
   logic [31:0]           type_shift;
   logic [31:0]           crc_shift;
   logic [CMP_WIDTH-1:0]  chunk_end;
   logic [CMP_WIDTH-1:0]  header_end;
   logic [CMP_WIDTH-1:0]  start_ext;
   logic [CMP_WIDTH-1:0]  fl_ext;
   logic                  sig_miss;
   logic                  at_eof;
   logic                  short_header;
   logic                  overrun;

   // start of file clears everything before the byte is parsed
   assign cur        = req_item.start_of_file ? STATE_CLEAR : cur_state;
   assign b          = req_item.in_byte;
   assign count_inc  = cur.field_count + 32'd1;
   assign last_field = (cur.field_count == 32'(FIELD_BYTES - 1));

   assign len_shift  = {((cur.field_count == '0) ? 24'd0 : cur.length_reg[23:0]), b};
   assign type_shift = {cur.type_reg[23:0], b};
   assign crc_shift  = {cur.crc_reg[23:0], b};

   assign start_ext  = CMP_WIDTH'(cur.chunk_start);
   assign fl_ext     = CMP_WIDTH'(file_length);
   assign chunk_end  = start_ext + CMP_WIDTH'(FRAMING_BYTES) + CMP_WIDTH'(cur.length_reg);
   assign header_end = start_ext + CMP_WIDTH'(HEADER_BYTES);

   assign sig_miss     = (b != SIG_BYTES[cur.field_count[2:0]]);
   assign at_eof       = (start_ext >= fl_ext);
   assign short_header = (header_end > fl_ext);
   assign overrun      = (chunk_end > fl_ext);

   // next state
   always_comb begin
      next_state = cur;
      case (cur.phase)
         PH_SIG: begin
            if (sig_miss) begin
               next_state.phase = PH_HALT;
            end else if (cur.field_count == 32'(SIG_LENGTH - 1)) begin
               next_state.field_count = '0;
               next_state.chunk_start = POSITION_WIDTH'(SIG_LENGTH);
               next_state.phase       = PH_LEN;
            end else begin
               next_state.field_count = count_inc;
            end
         end
         PH_LEN: begin
            if (cur.field_count == '0 && at_eof) begin
               next_state.phase = PH_END;
            end else if (cur.field_count == '0 && short_header) begin
               next_state.phase = PH_HALT;
            end else begin
               next_state.length_reg = len_shift;
               if (last_field) begin
                  next_state.field_count = '0;
                  next_state.type_reg    = '0;
                  next_state.phase       = PH_TYPE;
               end else begin
                  next_state.field_count = count_inc;
               end
            end
         end
         PH_TYPE: begin
            next_state.type_reg = type_shift;
            if (last_field) begin
               next_state.field_count = '0;
               if (overrun) begin
                  next_state.phase = PH_HALT;
               end else begin
                  next_state.crc_reg = '0;
                  next_state.phase   = (cur.length_reg != '0) ? PH_DATA : PH_CRC;
               end
            end else begin
               next_state.field_count = count_inc;
            end
         end
         PH_DATA: begin
            if (count_inc >= cur.length_reg) begin
               next_state.field_count = '0;
               next_state.phase       = PH_CRC;
            end else begin
               next_state.field_count = count_inc;
            end
         end
         PH_CRC: begin
            next_state.crc_reg = crc_shift;
            if (last_field) begin
               next_state.field_count = '0;
               next_state.phase       = PH_LEN;
               // saturating advance to the next chunk
               if (chunk_end > CMP_WIDTH'(POS_MAX)) begin
                  next_state.chunk_start = POS_MAX;
               end else begin
                  next_state.chunk_start = chunk_end[POSITION_WIDTH-1:0];
               end
            end else begin
               next_state.field_count = count_inc;
            end
         end
         default: begin
            next_state = cur;
         end
      endcase
   end

   // result
   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      case (cur.phase)
         PH_SIG: begin
            if (sig_miss) begin
               result_valid       = 1'b1;
               result.result_kind = KIND_ERROR;
               result.error_code  = ERR_BAD_SIGNATURE;
            end
         end
         PH_LEN: begin
            if (cur.field_count == '0 && !at_eof && short_header) begin
               result_valid       = 1'b1;
               result.result_kind = KIND_ERROR;
               result.error_code  = ERR_SHORT_HEADER;
            end
         end
         PH_TYPE: begin
            if (last_field && overrun) begin
               result_valid        = 1'b1;
               result.result_kind  = KIND_ERROR;
               result.chunk_type   = type_shift;
               result.chunk_length = cur.length_reg;
               result.error_code   = ERR_OVERRUN;
            end
         end
         PH_DATA: begin
            result_valid        = 1'b1;
            result.result_kind  = KIND_DATA;
            result.data_byte    = b;
            result.chunk_type   = cur.type_reg;
            result.byte_index   = cur.field_count;
            result.chunk_length = cur.length_reg;
         end
         PH_CRC: begin
            if (last_field) begin
               result_valid        = 1'b1;
               result.result_kind  = KIND_DESCRIPTOR;
               result.chunk_type   = cur.type_reg;
               result.chunk_length = cur.length_reg;
               result.stored_crc   = crc_shift;
            end
         end
         default: begin
            result_valid = 1'b0;
         end
      endcase
   end

endmodule

// File: design/png_chunk_stream_parser.sv
// Top level of the PNG chunk stream parser: input register, parse state, result register.
// A transaction accepted into the input register is parsed as it leaves it; its result is
// then shown on rsp_ from the result register.
// Throughput: one byte per clock while rsp_stall stays low; the parse state is the
// only loop.
// Reset (synchronous, active high) clears both stages, the parse state and file_length.
module png_chunk_stream_parser
   import pngcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  pngcp_req_type req_data,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output pngcp_rsp_type rsp_data,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data
);

   // input register stage
   logic            s1_valid_ff, s1_valid_in;
   pngcp_req_type   s1_req_ff;

   // parse state, committed as each byte leaves the input register
   pngcp_state_type state_ff, state_in;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   pngcp_rsp_type   rsp_ff;

   logic [31:0]     file_length_ff;

   logic            req_accept;
   logic            advance;
   logic            step_valid;
   pngcp_rsp_type   step_rsp;

   pngcp_step u_step (
      .cur_state    (state_ff),
      .req_item     (s1_req_ff),
      .file_length  (file_length_ff),
      .next_state   (state_in),
      .result_valid (step_valid),
      .result       (step_rsp)
   );

   // The byte in the input register moves on whenever the result slot is
   // empty or its transaction is being taken this cycle.
   assign advance    = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall  = s1_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      if (req_accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
   end

   // bytes that give no result still free the result slot if it was taken
   always_comb begin
      if (advance) begin
         rsp_valid_in = step_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         state_ff       <= STATE_CLEAR;
         file_length_ff <= '0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
         if (csr_write_enable) begin
            file_length_ff <= csr_write_data;
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_req_ff <= req_data;
      end
      if (advance && step_valid) begin
         rsp_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// File: design/pngcp_checker.sv
// Port-level checks for the PNG chunk stream parser, bound to the top level.
module pngcp_checker
   import pngcp_pkg::*;
(
   input logic          clock,
   input logic          reset,
   input logic          req_valid,
   input logic          req_stall,
   input logic          rsp_valid,
   input logic          rsp_stall,
   input pngcp_rsp_type rsp_data
);

   // a stalled result transaction holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result transaction changed");

   // result kind is data, descriptor or error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.result_kind == KIND_DATA ||
                     rsp_data.result_kind == KIND_DESCRIPTOR ||
                     rsp_data.result_kind == KIND_ERROR))
      else $error("unknown result kind");

   // data transactions carry no CRC and no error code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_kind == KIND_DATA |->
         rsp_data.stored_crc == '0 && rsp_data.error_code == '0)
      else $error("data transaction with descriptor or error fields set");

   // a fresh result is preceded by an accepted input transaction
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall, 2))
      else $error("result without a matching input transaction");

endmodule

bind png_chunk_stream_parser pngcp_checker u_pngcp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// File: tb/sv/png_chunk_checker.sv
// Checker for the PNG chunk stream parser: byte-level parse prediction and result comparison.
module png_chunk_checker
   import pngcp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_stall,
   input  pngcp_req_type req_data,
   input  logic          rsp_valid,
   input  logic          rsp_stall,
   input  pngcp_rsp_type rsp_data,
   input  logic          csr_write_enable,
   input  logic [31:0]   csr_write_data,
   output int unsigned   failures,
   output int unsigned   pending
);

   localparam logic [7:0] PNG_MAGIC [8] = '{
      8'h89, 8'h50, 8'h4E, 8'h47, 8'h0D, 8'h0A, 8'h1A, 8'h0A
   };
   localparam logic [63:0] POSITION_CEILING = 64'h0000_0000_FFFF_FFFF;

   pngcp_phase_type ph;
   logic [63:0]     file_pos;
   logic [63:0]     chunk_base;
   logic [31:0]     nfield;
   logic [31:0]     len_acc;
   logic [31:0]     type_acc;
   logic [31:0]     crc_acc;
   logic [31:0]     file_len;

   pngcp_rsp_type   expected_results [$];
   int unsigned     fail_total = 0;

   function automatic void clear_parse();
      ph         = PH_SIG;
      file_pos   = '0;
      chunk_base = '0;
      nfield     = '0;
      len_acc    = '0;
      type_acc   = '0;
      crc_acc    = '0;
   endfunction

   function automatic logic [63:0] saturate(input logic [63:0] value);
      return (value > POSITION_CEILING) ? POSITION_CEILING : value;
   endfunction

   // Advances the parse by one byte; returns 1 when the byte yields a result.
   function automatic bit parse_byte(input pngcp_req_type req, output pngcp_rsp_type res);
      logic [7:0] b;
      bit         produced;
      b        = req.in_byte;
      produced = 1'b0;
      res      = '0;
      if (req.start_of_file) clear_parse();
      case (ph)
         PH_SIG: begin
            if (b != PNG_MAGIC[nfield[2:0]]) begin
               ph              = PH_HALT;
               res.result_kind = KIND_ERROR;
               res.error_code  = ERR_BAD_SIGNATURE;
               return 1'b1;
            end
            nfield++;
            if (nfield >= 8) begin
               nfield     = '0;
               chunk_base = saturate(file_pos + 1);
               ph         = PH_LEN;
            end
         end
         PH_LEN: begin
            if (nfield == 0) begin
               if (chunk_base >= {32'd0, file_len}) begin
                  ph = PH_END;
                  return 1'b0;
               end
               if (chunk_base + 8 > {32'd0, file_len}) begin
                  ph              = PH_HALT;
                  res.result_kind = KIND_ERROR;
                  res.error_code  = ERR_SHORT_HEADER;
                  return 1'b1;
               end
               len_acc = '0;
            end
            len_acc = {len_acc[23:0], b};
            nfield++;
            if (nfield >= 4) begin
               nfield   = '0;
               type_acc = '0;
               ph       = PH_TYPE;
            end
         end
         PH_TYPE: begin
            type_acc = {type_acc[23:0], b};
            nfield++;
            if (nfield >= 4) begin
               nfield = '0;
               if (chunk_base + 12 + {32'd0, len_acc} > {32'd0, file_len}) begin
                  ph               = PH_HALT;
                  res.result_kind  = KIND_ERROR;
                  res.chunk_type   = type_acc;
                  res.chunk_length = len_acc;
                  res.error_code   = ERR_OVERRUN;
                  return 1'b1;
               end
               crc_acc = '0;
               ph      = (len_acc != 0) ? PH_DATA : PH_CRC;
            end
         end
         PH_DATA: begin
            res.result_kind  = KIND_DATA;
            res.data_byte    = b;
            res.chunk_type   = type_acc;
            res.byte_index   = nfield;
            res.chunk_length = len_acc;
            produced         = 1'b1;
            nfield++;
            if (nfield >= len_acc) begin
               nfield = '0;
               ph     = PH_CRC;
            end
         end
         PH_CRC: begin
            crc_acc = {crc_acc[23:0], b};
            nfield++;
            if (nfield >= 4) begin
               nfield           = '0;
               res.result_kind  = KIND_DESCRIPTOR;
               res.chunk_type   = type_acc;
               res.chunk_length = len_acc;
               res.stored_crc   = crc_acc;
               produced         = 1'b1;
               chunk_base       = saturate(chunk_base + 12 + {32'd0, len_acc});
               ph               = PH_LEN;
            end
         end
         default: return 1'b0;
      endcase
      file_pos = saturate(file_pos + 1);
      return produced;
   endfunction

   function automatic void check_field(input string field, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
         fail_total++;
      end
   endfunction

   always @(posedge clock) begin
      pngcp_rsp_type predicted;
      pngcp_rsp_type wanted;
      if (reset) begin
         clear_parse();
         file_len = '0;
         expected_results.delete();
      end else begin
         if (csr_write_enable) file_len = csr_write_data;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $error("result transaction with nothing expected (kind 0x%0h)",
                      rsp_data.result_kind);
               fail_total++;
            end else begin
               wanted = expected_results.pop_front();
               check_field("result_kind", 32'(wanted.result_kind), 32'(rsp_data.result_kind));
               check_field("data_byte", 32'(wanted.data_byte), 32'(rsp_data.data_byte));
               check_field("chunk_type", wanted.chunk_type, rsp_data.chunk_type);
               check_field("byte_index", wanted.byte_index, rsp_data.byte_index);
               check_field("chunk_length", wanted.chunk_length, rsp_data.chunk_length);
               check_field("stored_crc", wanted.stored_crc, rsp_data.stored_crc);
               check_field("error_code", 32'(wanted.error_code), 32'(rsp_data.error_code));
            end
         end
         if (req_valid && !req_stall) begin
            if (parse_byte(req_data, predicted)) expected_results.push_back(predicted);
         end
      end
      pending  <= expected_results.size();
      failures <= fail_total;
   end

endmodule

// File: tb/sv/png_chunk_stream_parser_tb.sv
// Testbench top for the PNG chunk stream parser: clock, reset, byte stimulus and verdict.
module png_chunk_stream_parser_tb;
   import pngcp_pkg::*;

   localparam int CYCLE_LIMIT   = 400000;
   localparam int DRAIN_LIMIT   = 5000;
   localparam int SETTLE_CYCLES = 6;    // a little over the latency of the input and result registers
   localparam int RANDOM_BYTES  = 300;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic          clock            = 1'b0;
   logic          reset            = 1'b1;
   logic          req_valid        = 1'b0;
   logic          req_stall;
   pngcp_req_type req_data         = '0;
   logic          rsp_valid;
   logic          rsp_stall        = 1'b0;
   pngcp_rsp_type rsp_data;
   logic          csr_write_enable = 1'b0;
   logic [31:0]   csr_write_data   = '0;

   int unsigned   failures;
   int unsigned   pending_results;
   int unsigned   cycle_count      = 0;
   idle_mode_type idle_mode        = IDLE_NONE;

   // Bytes of the current phase, waiting to go out as input transactions.
   pngcp_req_type byte_queue [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   png_chunk_stream_parser u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   png_chunk_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .failures         (failures),
      .pending          (pending_results)
   );

   // Hard stop, should a handshake hang.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** png_chunk_stream_parser: FAILED **");
         $finish;
      end
   end

   // Percentage of cycles in which the given side holds off.
   function automatic int unsigned idle_pct(input bit receiver_side);
      case (idle_mode)
         IDLE_SENDER:   return receiver_side ? 0 : 57;
         IDLE_RECEIVER: return receiver_side ? 57 : 0;
         IDLE_BOTH:     return 27;
         default:       return 0;
      endcase
   endfunction

   // Receiver: stall is free to change on any cycle.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < idle_pct(1'b1));
   end

   task automatic push_byte(input logic [7:0] value, input logic sof);
      pngcp_req_type item;
      item.in_byte       = value;
      item.start_of_file = sof;
      byte_queue.push_back(item);
   endtask

   // Chunk fields are big-endian on the wire.
   task automatic push_word(input logic [31:0] value);
      for (int i = 3; i >= 0; i--) push_byte(value[8*i +: 8], 1'b0);
   endtask

   task automatic push_signature();
      for (int i = 0; i < SIG_LENGTH; i++) push_byte(SIG_BYTES[i], i == 0);
   endtask

   task automatic push_junk(input int unsigned count);
      repeat (count) push_byte(8'($urandom), 1'b0);
   endtask

   // Mostly letter codes as real files carry them, now and then any 32-bit value.
   function automatic logic [31:0] random_chunk_type();
      logic [31:0] word;
      word = '0;
      if ($urandom_range(3) == 0) return $urandom;
      for (int i = 0; i < 4; i++) begin
         word = {word[23:0], 8'(($urandom_range(1) ? 8'h41 : 8'h61) + $urandom_range(25))};
      end
      return word;
   endfunction

   // One file for the configured length. Most are well formed and fill the length
   // exactly or nearly so; the tail that is left over lands in a short header or an
   // overrun. The rest: noise, a broken signature, a deliberate overrun, or a file
   // cut short by the next start of file.
   task automatic push_random_file(input logic [31:0] flen);
      int unsigned pick;
      int unsigned first;
      int unsigned chunks;
      int unsigned corrupt_at;
      int unsigned cap;
      logic [63:0] remaining;
      logic [63:0] over;
      logic [31:0] body_len;
      bit          overrun;
      pick  = $urandom_range(99);
      first = byte_queue.size();
      if (pick < 6) begin
         repeat ($urandom_range(1, 12)) push_byte(8'($urandom), $urandom_range(3) == 0);
         return;
      end
      if (pick < 16) begin
         corrupt_at = $urandom_range(SIG_LENGTH - 1);
         for (int i = 0; i < SIG_LENGTH; i++) begin
            push_byte((i == corrupt_at) ? SIG_BYTES[i] ^ 8'($urandom_range(1, 255))
                                        : SIG_BYTES[i], i == 0);
         end
         push_junk($urandom_range(0, 4));
         return;
      end
      overrun = (pick < 26);
      push_signature();
      remaining = (flen >= HEADER_BYTES) ? 64'(flen) - HEADER_BYTES : 64'd0;
      chunks    = 0;
      while (remaining >= FRAMING_BYTES && chunks < 6) begin
         if (overrun && ($urandom_range(2) == 0 || remaining < 40 || chunks == 5)) begin
            // Whole chunk ends one to four bytes past the file end.
            over     = remaining - 11 + $urandom_range(3);
            body_len = (over > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : over[31:0];
            push_word(body_len);
            push_word(random_chunk_type());
            push_junk($urandom_range(0, 3));
            return;
         end
         cap = (remaining - FRAMING_BYTES > 24) ? 24 : int'(remaining - FRAMING_BYTES);
         if (cap < 24 && $urandom_range(1) == 0) body_len = cap;
         else if ($urandom_range(7) == 0) body_len = 0;
         else body_len = $urandom_range(0, cap);
         push_word(body_len);
         push_word(random_chunk_type());
         push_junk(body_len);
         push_word($urandom);
         remaining -= FRAMING_BYTES + body_len;
         chunks++;
      end
      if (remaining < FRAMING_BYTES) begin
         push_junk(int'(remaining));
         push_junk($urandom_range(0, 3));
      end
      if (pick >= 26 && pick < 36) begin
         repeat ($urandom_range(1, byte_queue.size() - first - 1)) void'(byte_queue.pop_back());
      end
   endtask

   function automatic logic [31:0] random_file_length();
      case ($urandom_range(9))
         0, 1, 2, 3, 4: return $urandom_range(20, 90);
         5:             return $urandom_range(0, 19);
         6, 7:          return 32'hFFFF_FFFF;
         default:       return $urandom;
      endcase
   endfunction

   // Sends the queued bytes; a stalled transaction is held unchanged.
   task automatic send_queue();
      int unsigned idx;
      idx = 0;
      while (idx < byte_queue.size()) begin
         @(posedge clock);
         if (req_valid && !req_stall) idx++;
         if (req_valid && req_stall) begin
            // hold
         end else if (idx < byte_queue.size() && $urandom_range(99) >= idle_pct(1'b0)) begin
            req_valid <= 1'b1;
            req_data  <= byte_queue[idx];
         end else begin
            req_valid <= 1'b0;
         end
      end
      byte_queue.delete();
   endtask

   // Waits for every expected result, then lets bytes with no result clear the pipe.
   task automatic drain();
      int unsigned waited;
      waited = 0;
      repeat (2) @(posedge clock);
      while (pending_results != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_file_length(input logic [31:0] value);
      drain();
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   initial begin
      int unsigned   random_bytes;
      int unsigned   phase_count;
      logic [31:0]   flen;
      random_bytes = 0;
      phase_count  = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // file_length still at its reset value of zero: a clean signature finishes the
      // file with nothing out, then a signature broken on its third byte.
      push_signature();
      push_junk(2);
      push_byte(8'h89, 1'b1);
      push_byte(8'h50, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      send_queue();

      // Largest length: a data chunk, an empty chunk, then an all-ones length.
      write_file_length(32'hFFFF_FFFF);
      idle_mode = IDLE_BOTH;
      push_signature();
      push_word(32'd2);
      push_word("IHDR");
      push_byte(8'h00, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_word(32'hDEAD_BEEF);
      push_word(32'd0);
      push_word("IEND");
      push_word(32'hAE42_6082);
      push_word(32'hFFFF_FFFF);
      push_word("IDAT");
      send_queue();

      // Too little room left for a chunk header.
      write_file_length(32'd9);
      push_signature();
      push_byte(8'h00, 1'b0);
      send_queue();

      // One empty chunk that fills the file exactly; the byte after is ignored.
      write_file_length(32'd20);
      push_signature();
      push_word(32'd0);
      push_word("IEND");
      push_word(32'hAE42_6082);
      push_byte(8'h55, 1'b0);
      send_queue();

      // Zero length still has the signature checked, here failing on the last byte.
      write_file_length(32'd0);
      for (int i = 0; i < SIG_LENGTH - 1; i++) push_byte(SIG_BYTES[i], i == 0);
      push_byte(8'h0B, 1'b0);
      send_queue();

      // Random phases, each with its own file length and idling pattern.
      while (random_bytes < RANDOM_BYTES) begin
         flen = random_file_length();
         write_file_length(flen);
         idle_mode = idle_mode_type'(phase_count % 4);
         repeat ($urandom_range(1, 3)) push_random_file(flen);
         random_bytes += byte_queue.size();
         send_queue();
         phase_count++;
      end

      drain();
      if (pending_results != 0) begin
         $error("%0d expected results never arrived", pending_results);
      end
      if (failures == 0 && pending_results == 0) begin
         $display("** png_chunk_stream_parser: PASSED **");
      end else begin
         $display("** png_chunk_stream_parser: FAILED **");
      end
      $finish;
   end

endmodule
